// File: design/stpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stpc_pkg;

    localparam int VAL_W = 6;

    typedef logic [VAL_W-1:0] val_t;

    typedef enum logic [1:0] {
        ST_ELEM        = 2'd0,
        ST_DONE        = 2'd1,
        ST_BAD_SIZE    = 2'd2,
        ST_NOT_STARTED = 2'd3
    } status_t;

    // one write port and one registered read port of the permutation store
    typedef struct packed {
        logic wr_en;
        val_t wr_addr;
        val_t wr_data;
        logic rd_en;
        val_t rd_addr;
    } mem_req_t;

endpackage

`default_nettype wire

// File: design/stpc_perm_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module stpc_perm_mem #(
    parameter int DEPTH = 63
) (
    input  wire logic            aclk,
    input  wire stpc_pkg::mem_req_t req,
    output stpc_pkg::val_t       rd_data
);

    localparam int AW = $clog2(DEPTH);

    stpc_pkg::val_t mem [0:DEPTH-1];
    stpc_pkg::val_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/stpc_slot_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// maps a one-based position of the rotated permutation to its store slot
module stpc_slot_unit (
    input  wire stpc_pkg::val_t base,
    input  wire stpc_pkg::val_t pos,
    input  wire stpc_pkg::val_t size,
    output stpc_pkg::val_t      slot
);

    logic [7:0] sum;
    logic [7:0] twice;
    logic [7:0] once;
    logic [7:0] diff;

    assign sum   = 8'(base) + 8'(pos) + 8'(size) - 8'd2;
    assign twice = {1'b0, size, 1'b0};
    assign once  = {2'b00, size};

    // sum stays below three times the size, so two conditional subtracts do
    always_comb begin
        priority if (sum >= twice) begin
            diff = sum - twice;
        end else if (sum >= once) begin
            diff = sum - once;
        end else begin
            diff = sum;
        end
    end

    assign slot = diff[5:0];

endmodule

`default_nettype wire

// File: design/sigma_tau_permutation_cycle_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Walks a Hamiltonian cycle over the permutations of odd size n (perm_size,
// APB register at byte address 0, 5 to MAX_SIZE). A restart transfer loads the
// identity permutation and gives no result; each later tick emits the current
// permutation as n results (positions 1 to n, last one flagged), then applies
// the next move. A tick does six reads of single elements through the one read
// port of the permutation store, a decision step, the streaming of the
// elements, then applies the move and, for a tau move, writes the swap. Status
// results (cycle complete, bad size, not restarted) are single results loaded
// from a status state. The block takes one input at a time and is not ready
// while a tick is in work.
module sigma_tau_permutation_cycle_unit #(
    parameter int MAX_SIZE = 63
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_restart,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_elem_value,
    output logic [5:0]       m_elem_pos,
    output logic             m_last_elem,
    output logic             m_move_tau,
    output logic             m_is_final,
    output logic [1:0]       m_status,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [6:0] MaxSizeW = 7'(MAX_SIZE);
    localparam logic [5:0] MinSize  = 6'd5;
    localparam logic       RegSize  = 1'b0;

    // gathered values: positions 1..4, position n, element after the max
    localparam logic [2:0] GV1 = 3'd0;
    localparam logic [2:0] GV2 = 3'd1;
    localparam logic [2:0] GV3 = 3'd2;
    localparam logic [2:0] GV4 = 3'd3;
    localparam logic [2:0] GVN = 3'd4;
    localparam logic [2:0] GVR = 3'd5;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_FILL     = 10'b00_0000_0010,
        S_STATUS   = 10'b00_0000_0100,
        S_GATHER_A = 10'b00_0000_1000,
        S_GATHER_D = 10'b00_0001_0000,
        S_DECIDE   = 10'b00_0010_0000,
        S_EMIT     = 10'b00_0100_0000,
        S_MOVE     = 10'b00_1000_0000,
        S_SWAP1    = 10'b01_0000_0000,
        S_SWAP2    = 10'b10_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    stpc_pkg::val_t       size_reg, size_next;
    stpc_pkg::val_t       n_reg, n_next;
    stpc_pkg::val_t       base_reg, base_next;
    stpc_pkg::val_t       maxp_reg, maxp_next;
    stpc_pkg::val_t       up_reg, up_next;
    logic                 started_reg, started_next;
    logic                 finished_reg, finished_next;
    logic [6:0]           cnt_reg, cnt_next;
    stpc_pkg::val_t       emit_pos_reg, emit_pos_next;
    logic                 pend_reg, pend_next;
    stpc_pkg::status_t    code_reg, code_next;
    logic                 fin_reg, fin_next;
    logic                 tau_reg, tau_next;
    stpc_pkg::val_t       gath_reg [0:5];
    stpc_pkg::val_t       gath_next [0:5];

    logic                 out_valid_reg, out_valid_next;
    stpc_pkg::val_t       out_value_reg, out_value_next;
    stpc_pkg::val_t       out_pos_reg, out_pos_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_tau_reg, out_tau_next;
    logic                 out_fin_reg, out_fin_next;
    stpc_pkg::status_t    out_status_reg, out_status_next;

    stpc_pkg::mem_req_t   mem_req;
    stpc_pkg::val_t       rd_data;
    stpc_pkg::val_t       slot_pos;
    stpc_pkg::val_t       slot;

    logic                 cfg_wr;
    logic                 size_ok;
    logic                 out_free;
    logic                 load;
    logic                 issue;
    stpc_pkg::val_t       bnext;
    logic [6:0]           r_inc;
    logic [6:0]           n_wide;
    logic                 up_full;
    logic                 fin_now;
    logic                 tau_now;

    stpc_slot_unit u_slot (
        .base (base_reg),
        .pos  (slot_pos),
        .size (n_reg),
        .slot (slot)
    );

    stpc_perm_mem #(
        .DEPTH (MAX_SIZE)
    ) u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == RegSize) ? {26'd0, size_reg} : 32'd0;

    assign size_ok  = size_reg[0] && (size_reg >= MinSize) && ({1'b0, size_reg} <= MaxSizeW);
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    assign bnext   = (base_reg == n_reg) ? 6'd1 : base_reg + 6'd1;
    assign n_wide  = {1'b0, n_reg};
    // one more than the element that follows the max, or than position 3 when the max leads
    assign r_inc   = (maxp_reg != base_reg) ? {1'b0, gath_reg[GVR]} + 7'd1
                                            : {1'b0, gath_reg[GV3]} + 7'd1;
    assign up_full = (up_reg == n_reg - 6'd2);
    assign fin_now = up_full && (gath_reg[GV1] == n_reg) && (gath_reg[GV2] == 6'd1);
    assign tau_now = ((r_inc < n_wide) && ({1'b0, gath_reg[GV2]} == r_inc))
                  || ((r_inc == n_wide) && (gath_reg[GV2] == 6'd2))
                  || (up_full && (maxp_reg == bnext));

    always_comb begin
        state_next      = state_reg;
        size_next       = size_reg;
        n_next          = n_reg;
        base_next       = base_reg;
        maxp_next       = maxp_reg;
        up_next         = up_reg;
        started_next    = started_reg;
        finished_next   = finished_reg;
        cnt_next        = cnt_reg;
        emit_pos_next   = emit_pos_reg;
        pend_next       = pend_reg;
        code_next       = code_reg;
        fin_next        = fin_reg;
        tau_next        = tau_reg;
        gath_next       = gath_reg;
        out_value_next  = out_value_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        out_tau_next    = out_tau_reg;
        out_fin_next    = out_fin_reg;
        out_status_next = out_status_reg;
        mem_req         = '0;
        slot_pos        = cnt_reg[5:0];
        load            = 1'b0;
        issue           = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    n_next = size_reg;
                    if (s_restart) begin
                        if (!size_ok) begin
                            started_next  = 1'b0;
                            finished_next = 1'b0;
                            code_next     = stpc_pkg::ST_BAD_SIZE;
                            state_next    = S_STATUS;
                        end else begin
                            base_next     = 6'd1;
                            maxp_next     = size_reg;
                            up_next       = size_reg - 6'd2;
                            started_next  = 1'b1;
                            finished_next = 1'b0;
                            cnt_next      = '0;
                            state_next    = S_FILL;
                        end
                    end else if (!started_reg || !size_ok) begin
                        code_next  = stpc_pkg::ST_NOT_STARTED;
                        state_next = S_STATUS;
                    end else if (finished_reg) begin
                        code_next  = stpc_pkg::ST_DONE;
                        state_next = S_STATUS;
                    end else begin
                        cnt_next   = '0;
                        state_next = S_GATHER_A;
                    end
                end
            end
            S_FILL: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cnt_reg[5:0];
                mem_req.wr_data = cnt_reg[5:0] + 6'd1;
                cnt_next        = cnt_reg + 7'd1;
                if (cnt_reg[5:0] == n_reg - 6'd1) begin
                    state_next = S_IDLE;
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    load            = 1'b1;
                    out_value_next  = '0;
                    out_pos_next    = '0;
                    out_last_next   = 1'b1;
                    out_tau_next    = 1'b0;
                    out_fin_next    = 1'b0;
                    out_status_next = code_reg;
                    state_next      = S_IDLE;
                end
            end
            S_GATHER_A: begin
                mem_req.rd_en = 1'b1;
                if (cnt_reg[2:0] == GVR) begin
                    mem_req.rd_addr = (maxp_reg == n_reg) ? 6'd0 : maxp_reg;
                end else begin
                    slot_pos        = (cnt_reg[2:0] == GVN) ? n_reg : cnt_reg[5:0] + 6'd1;
                    mem_req.rd_addr = slot;
                end
                state_next = S_GATHER_D;
            end
            S_GATHER_D: begin
                gath_next[cnt_reg[2:0]] = rd_data;
                if (cnt_reg[2:0] == GVR) begin
                    state_next = S_DECIDE;
                end else begin
                    cnt_next   = cnt_reg + 7'd1;
                    state_next = S_GATHER_A;
                end
            end
            S_DECIDE: begin
                fin_next      = fin_now;
                tau_next      = !fin_now && tau_now;
                cnt_next      = 7'd1;
                emit_pos_next = 6'd1;
                pend_next     = 1'b0;
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                // read of the next element overlaps the transfer of this one
                load  = pend_reg && out_free;
                issue = (cnt_reg <= n_wide) && (!pend_reg || load);
                if (issue) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = slot;
                    cnt_next        = cnt_reg + 7'd1;
                end
                pend_next = issue || (pend_reg && !load);
                if (load) begin
                    out_value_next  = rd_data;
                    out_pos_next    = emit_pos_reg;
                    out_last_next   = (emit_pos_reg == n_reg);
                    out_tau_next    = tau_reg;
                    out_fin_next    = fin_reg;
                    out_status_next = stpc_pkg::ST_ELEM;
                    emit_pos_next   = emit_pos_reg + 6'd1;
                    if (emit_pos_reg == n_reg) begin
                        state_next = S_MOVE;
                    end
                end
            end
            S_MOVE: begin
                if (fin_reg) begin
                    finished_next = 1'b1;
                    state_next    = S_IDLE;
                end else if (tau_reg) begin
                    up_next = up_reg
                            + 6'(gath_reg[GV2] < gath_reg[GV3])
                            + 6'(gath_reg[GVN] < gath_reg[GV2])
                            - 6'(gath_reg[GVN] < gath_reg[GV1])
                            - 6'(gath_reg[GV1] < gath_reg[GV3]);
                    if (maxp_reg == base_reg) begin
                        maxp_next = bnext;
                    end else if (maxp_reg == bnext) begin
                        maxp_next = base_reg;
                    end
                    state_next = S_SWAP1;
                end else begin
                    up_next = up_reg
                            + 6'(gath_reg[GV1] < gath_reg[GV2])
                            + 6'(gath_reg[GV2] < gath_reg[GV4])
                            - 6'(gath_reg[GV1] < gath_reg[GV3])
                            - 6'(gath_reg[GV3] < gath_reg[GV4]);
                    base_next  = bnext;
                    state_next = S_IDLE;
                end
            end
            S_SWAP1: begin
                slot_pos        = 6'd1;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = slot;
                mem_req.wr_data = gath_reg[GV2];
                state_next      = S_SWAP2;
            end
            S_SWAP2: begin
                slot_pos        = 6'd2;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = slot;
                mem_req.wr_data = gath_reg[GV1];
                state_next      = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr && paddr[2] == RegSize) begin
            size_next     = pwdata[5:0];
            started_next  = 1'b0;
            finished_next = 1'b0;
        end

        out_valid_next = load || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            size_reg      <= 6'd5;
            base_reg      <= 6'd1;
            maxp_reg      <= '0;
            up_reg        <= '0;
            started_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            cnt_reg       <= '0;
            emit_pos_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            base_reg      <= base_next;
            maxp_reg      <= maxp_next;
            up_reg        <= up_next;
            started_reg   <= started_next;
            finished_reg  <= finished_next;
            cnt_reg       <= cnt_next;
            emit_pos_reg  <= emit_pos_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        code_reg       <= code_next;
        fin_reg        <= fin_next;
        tau_reg        <= tau_next;
        gath_reg       <= gath_next;
        out_value_reg  <= out_value_next;
        out_pos_reg    <= out_pos_next;
        out_last_reg   <= out_last_next;
        out_tau_reg    <= out_tau_next;
        out_fin_reg    <= out_fin_next;
        out_status_reg <= out_status_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_elem_value = out_value_reg;
    assign m_elem_pos   = out_pos_reg;
    assign m_last_elem  = out_last_reg;
    assign m_move_tau   = out_tau_reg;
    assign m_is_final   = out_fin_reg;
    assign m_status     = out_status_reg;

`ifndef NO_ASSERTIONS
    a_base_range: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg && state_reg != S_FILL && state_reg != S_IDLE
        |-> base_reg != 6'd0 && base_reg <= n_reg)
        else $error("base index out of range while walking");

    a_maxp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg && state_reg != S_FILL && state_reg != S_IDLE
        |-> maxp_reg != 6'd0 && maxp_reg <= n_reg)
        else $error("max position out of range while walking");

    a_fin_needs_start: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |-> started_reg)
        else $error("finished without a valid restart");

    a_elem_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg == stpc_pkg::ST_ELEM
        |-> out_pos_reg != 6'd0 && out_last_reg == (out_pos_reg == n_reg))
        else $error("element transfer with bad position or last flag");

    a_emit_quiet_in: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> !mem_req.wr_en && !s_ready)
        else $error("store write or input transfer during streaming");
`endif

endmodule

`default_nettype wire
